FILE: sv/arbw_pkg.sv
// Shared types and constants for the alpha recovery core.
`default_nettype none
package arbw_pkg;

    localparam int PIX_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int COLOR_W   = 16;
    localparam int NUM_W     = 17;  // byte * 512 + alpha
    localparam int DEN_W     = 9;   // 2 * alpha
    localparam int LANES     = 3;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int ALPHA_LSB = 24;

    localparam logic [BYTE_W-1:0] ALPHA_FULL = 8'hFF;

    typedef logic [LANES-1:0][NUM_W-1:0]   t_num_vec;
    typedef logic [LANES-1:0][COLOR_W-1:0] t_color_vec;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input transaction this cycle
        logic load_item;  // load output register from the current item
        logic load_pend;  // capture last-pixel summary, start divider
        logic div_step;   // one restoring-division step
        logic load_sum;   // load output register from the pending summary
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_valid;
    } t_status;

endpackage
`default_nettype wire

FILE: sv/arbw_div.sv
// Three-lane bit-serial restoring divider with a shared divisor.
`default_nettype none
module arbw_div (
    input  wire                   i_clk,
    input  wire                   i_start,
    input  wire                   i_step,
    input  arbw_pkg::t_num_vec    i_num,
    input  wire  [arbw_pkg::DEN_W-1:0] i_den,
    output arbw_pkg::t_color_vec  o_quot
);
    import arbw_pkg::*;

    logic [DEN_W-1:0]              r_den;
    logic [LANES-1:0][NUM_W-1:0]   r_q;
    logic [LANES-1:0][DEN_W-1:0]   r_rem;
    logic [LANES-1:0][NUM_W-1:0]   n_q;
    logic [LANES-1:0][DEN_W-1:0]   n_rem;

    always_comb begin
        logic [DEN_W:0] sh;
        logic [DEN_W:0] diff;
        for (int l = 0; l < LANES; l++) begin
            sh   = {r_rem[l], r_q[l][NUM_W-1]};
            diff = sh - {1'b0, r_den};
            if (sh >= {1'b0, r_den}) begin
                n_rem[l] = diff[DEN_W-1:0];
                n_q[l]   = {r_q[l][NUM_W-2:0], 1'b1};
            end else begin
                n_rem[l] = sh[DEN_W-1:0];
                n_q[l]   = {r_q[l][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int l = 0; l < LANES; l++) begin
                r_q[l]   <= i_num[l];
                r_rem[l] <= '0;
            end
        end else if (i_step) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    // quotient never exceeds 16 bits for these operands
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quot[l] = r_q[l][COLOR_W-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: sv/arbw_datapath.sv
// Datapath: alpha recovery, frame delta tracking, summary and output register.
`default_nettype none
module arbw_datapath (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  arbw_pkg::t_cmd              i_cmd,
    input  wire  [arbw_pkg::PIX_W-1:0]  i_blk,
    input  wire  [arbw_pkg::PIX_W-1:0]  i_wht,
    input  wire                         i_last,
    input  wire                         i_empty,
    input  wire                         i_out_ready,
    output arbw_pkg::t_status           o_status,
    output logic [arbw_pkg::PIX_W-1:0]  o_pix,
    output logic                        o_pix_valid,
    output logic                        o_sum_valid,
    output logic                        o_uni_alpha,
    output logic                        o_uni_color,
    output arbw_pkg::t_color_vec        o_color,
    output logic [arbw_pkg::BYTE_W-1:0] o_frame_alpha
);
    import arbw_pkg::*;

    logic [PIX_W-1:0]  r_first;
    logic [PIX_W-1:0]  r_accum;
    logic              r_have;

    logic [PIX_W-1:0]  r_pend_pix;
    logic              r_pend_ua;
    logic              r_pend_uc;
    logic [BYTE_W-1:0] r_pend_fa;
    logic              r_pend_div;

    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_pv;
    logic              r_out_sv;
    logic              r_out_ua;
    logic              r_out_uc;
    t_color_vec        r_out_color;
    logic [BYTE_W-1:0] r_out_fa;

    logic [BYTE_W-1:0] alpha;
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  first_eff;
    logic [PIX_W-1:0]  accum_eff;
    logic [BYTE_W-1:0] fa;
    logic              ua;
    logic              uc;
    t_num_vec          div_num;
    logic [DEN_W-1:0]  div_den;
    t_color_vec        quot;

    always_comb begin
        alpha     = ALPHA_FULL + i_blk[15:8] - i_wht[15:8];
        pix       = {alpha, i_blk[ALPHA_LSB-1:0]};
        first_eff = r_have ? r_first : pix;
        accum_eff = (r_have ? r_accum : '0) | (first_eff ^ pix);
        fa        = first_eff[PIX_W-1:ALPHA_LSB];
        ua        = (accum_eff[PIX_W-1:ALPHA_LSB] == '0);
        uc        = ua && (accum_eff[ALPHA_LSB-1:0] == '0);
        div_den   = {fa, 1'b0};
        for (int l = 0; l < LANES; l++) begin
            div_num[l] = {first_eff[l*BYTE_W +: BYTE_W], {(NUM_W-BYTE_W){1'b0}}}
                       + {{(NUM_W-BYTE_W){1'b0}}, fa};
        end
    end

    arbw_div u_div (
        .i_clk   (i_clk),
        .i_start (i_cmd.load_pend),
        .i_step  (i_cmd.div_step),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (quot)
    );

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_accum <= '0;
            r_have  <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_empty || i_last) begin
                r_first <= '0;
                r_accum <= '0;
                r_have  <= 1'b0;
            end else begin
                r_first <= first_eff;
                r_accum <= accum_eff;
                r_have  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pend) begin
            r_pend_pix <= pix;
            r_pend_ua  <= ua;
            r_pend_uc  <= uc;
            r_pend_fa  <= ua ? fa : '0;
            r_pend_div <= uc && (fa != '0);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_item || i_cmd.load_sum) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_out_color <= '0;
            if (i_empty) begin
                r_out_pix <= '0;
                r_out_pv  <= 1'b0;
                r_out_sv  <= 1'b1;
                r_out_ua  <= 1'b1;
                r_out_uc  <= 1'b1;
                r_out_fa  <= ALPHA_FULL;
            end else begin
                r_out_pix <= pix;
                r_out_pv  <= 1'b1;
                r_out_sv  <= 1'b0;
                r_out_ua  <= 1'b0;
                r_out_uc  <= 1'b0;
                r_out_fa  <= '0;
            end
        end else if (i_cmd.load_sum) begin
            r_out_pix   <= r_pend_pix;
            r_out_pv    <= 1'b1;
            r_out_sv    <= 1'b1;
            r_out_ua    <= r_pend_ua;
            r_out_uc    <= r_pend_uc;
            r_out_fa    <= r_pend_fa;
            r_out_color <= r_pend_div ? quot : '0;
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_pix              = r_out_pix;
    assign o_pix_valid        = r_out_pv;
    assign o_sum_valid        = r_out_sv;
    assign o_uni_alpha        = r_out_ua;
    assign o_uni_color        = r_out_uc;
    assign o_color            = r_out_color;
    assign o_frame_alpha      = r_out_fa;

endmodule
`default_nettype wire

FILE: sv/arbw_ctrl.sv
// Controller: input handshake, divider sequencing and summary load.
`default_nettype none
module arbw_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_last,
    input  wire                i_in_empty,
    input  wire                i_out_ready,
    input  arbw_pkg::t_status  i_status,
    output logic               o_in_ready,
    output arbw_pkg::t_cmd     o_cmd
);
    import arbw_pkg::*;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_SUM = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             out_free;
    logic             accept;

    assign out_free   = !i_status.out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_RUN) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.accept = accept;
        unique case (r_state)
            ST_RUN: begin
                if (accept) begin
                    if (!i_in_empty && i_in_last) begin
                        o_cmd.load_pend = 1'b1;
                        n_cnt           = '0;
                        n_state         = ST_DIV;
                    end else begin
                        o_cmd.load_item = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    o_cmd.load_sum = 1'b1;
                    n_state        = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: sv/alpha_recover_black_white_core.sv
// Top level of the alpha recovery core: pixel pairs in, alpha pixels and frame summary out.
//
//  channel    dir  tdata                                         tlast          tuser
//  s_axis     in   [31:0] black, [63:32] white                   last_pixel     [0] empty_frame
//  m_axis     out  [31:0] pixel, [47:32] low, [63:48] mid,       summary_valid  [0] pixel_valid,
//                  [79:64] high, [87:80] frame_alpha                            [1] uni_alpha,
//                                                                               [2] uni_color
//
// Ordinary pixels and empty-frame items may stream back to back while the output is drained.
// A last pixel runs the 17-step bit-serial divider (three lanes, one shared divisor), so
// no new transaction is taken until the divider is done and the summary is loaded.
// Synchronous active-low reset clears frame state and control; no clearing pass.
// A single output register parts the two sides; input is held off only when that register
// is full and not drained, or while the divider runs or the summary waits for the register.
`default_nettype none
module alpha_recover_black_white_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [63:0] i_s_axis_tdata,   // black_pixel, white_pixel
    input  wire         i_s_axis_tlast,
    input  wire  [0:0]  i_s_axis_tuser,   // empty_frame
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata,   // pixel_out, color_low, color_mid, color_high,
                                          // frame_alpha
    output logic        o_m_axis_tlast,
    output logic [2:0]  o_m_axis_tuser    // pixel_valid, uni_alpha, uni_color
);
    import arbw_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic [PIX_W-1:0]  pix;
    logic              pix_valid;
    logic              uni_alpha;
    logic              uni_color;
    t_color_vec        color;
    logic [BYTE_W-1:0] frame_alpha;

    arbw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_last   (i_s_axis_tlast),
        .i_in_empty  (i_s_axis_tuser[0]),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_in_ready  (o_s_axis_tready),
        .o_cmd       (cmd)
    );

    arbw_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_blk         (i_s_axis_tdata[31:0]),
        .i_wht         (i_s_axis_tdata[63:32]),
        .i_last        (i_s_axis_tlast),
        .i_empty       (i_s_axis_tuser[0]),
        .i_out_ready   (i_m_axis_tready),
        .o_status      (status),
        .o_pix         (pix),
        .o_pix_valid   (pix_valid),
        .o_sum_valid   (o_m_axis_tlast),
        .o_uni_alpha   (uni_alpha),
        .o_uni_color   (uni_color),
        .o_color       (color),
        .o_frame_alpha (frame_alpha)
    );

    assign o_m_axis_tvalid = status.out_valid;
    assign o_m_axis_tdata  = {frame_alpha, color[2], color[1], color[0], pix};
    assign o_m_axis_tuser  = {uni_color, uni_alpha, pix_valid};

endmodule
`default_nettype wire
